// ===== rtl/lnx_pkg.sv =====
package lnx_pkg;

   // Operation codes carried by an input item
   localparam logic [1:0] OP_SET_PIN     = 2'd0;
   localparam logic [1:0] OP_SEND_BYTE   = 2'd1;
   localparam logic [1:0] OP_SEND_NIBBLE = 2'd2;
   localparam logic [1:0] OP_CURSOR      = 2'd3;

   // Expander pin positions in the shadow byte
   localparam logic [2:0] PIN_RS = 3'd0;
   localparam logic [2:0] PIN_RW = 3'd1;
   localparam logic [2:0] PIN_EN = 3'd2;
   localparam logic [2:0] PIN_D7 = 3'd7;

   localparam logic [7:0] ADDR_RESET    = 8'd78;
   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

   // DDRAM start address of each display line
   localparam logic [7:0] ROW_BASE [4] = '{8'd0, 8'd64, 8'd20, 8'd84};

   // Positions in the pin update sequence of one byte
   localparam logic [3:0] STEP_RS         = 4'd0;
   localparam logic [3:0] STEP_RW         = 4'd1;
   localparam logic [3:0] STEP_EN_CLEAR   = 4'd2;
   localparam logic [3:0] STEP_HI_FIRST   = 4'd3;
   localparam logic [3:0] STEP_HI_STROBE  = 4'd7;
   localparam logic [3:0] STEP_HI_RELEASE = 4'd8;
   localparam logic [3:0] STEP_LO_FIRST   = 4'd9;
   localparam logic [3:0] STEP_LO_STROBE  = 4'd13;
   localparam logic [3:0] STEP_LO_RELEASE = 4'd14;

   // One decoded item, ready for stepping
   typedef struct packed {
      logic       is_pin;
      logic [2:0] pin;
      logic       level;
      logic       rs;
      logic [7:0] data;
      logic [3:0] last_step;
   } lnx_item_type;

   // One pin change
   typedef struct packed {
      logic [2:0] pin;
      logic       level;
   } lnx_update_type;

   // One expander write handed to the output stage
   typedef struct packed {
      logic [7:0] expander_byte;
      logic       last;
   } lnx_write_type;

   // Pin change made at a given position of the byte sequence
   function automatic lnx_update_type lnx_step(input logic [3:0] step, input logic rs,
                                               input logic [7:0] data);
      lnx_update_type u;
      logic [1:0]     k;
      u.pin   = PIN_EN;
      u.level = 1'b0;
      k       = 2'd0;
      if (step >= STEP_HI_FIRST && step < STEP_HI_STROBE) begin
         k       = 2'(step - STEP_HI_FIRST);
         u.pin   = PIN_D7 - {1'b0, k};
         u.level = data[3'd7 - {1'b0, k}];
      end else if (step >= STEP_LO_FIRST && step < STEP_LO_STROBE) begin
         k       = 2'(step - STEP_LO_FIRST);
         u.pin   = PIN_D7 - {1'b0, k};
         u.level = data[3'd3 - {1'b0, k}];
      end else begin
         case (step)
            STEP_RS: begin
               u.pin   = PIN_RS;
               u.level = rs;
            end
            STEP_RW: begin
               u.pin   = PIN_RW;
               u.level = 1'b0;
            end
            STEP_HI_STROBE, STEP_LO_STROBE: begin
               u.pin   = PIN_EN;
               u.level = 1'b1;
            end
            default: begin
               // enable clear and both releases drop EN
               u.pin   = PIN_EN;
               u.level = 1'b0;
            end
         endcase
      end
      return u;
   endfunction

endpackage

// ===== rtl/lnx_channels.sv =====
interface lnx_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [2:0] pin_index;
   logic       pin_value;
   logic       register_select;
   logic [7:0] data_byte;
   logic [5:0] column;
   logic [1:0] row;

   modport source (output valid, operation, pin_index, pin_value, register_select,
                   data_byte, column, row, input ready);
   modport sink (input valid, operation, pin_index, pin_value, register_select,
                 data_byte, column, row, output ready);
endinterface

interface lnx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] bus_address;
   logic [7:0] expander_byte;
   logic       last;

   modport source (output valid, bus_address, expander_byte, last, input ready);
   modport sink (input valid, bus_address, expander_byte, last, output ready);
endinterface

// ===== rtl/lnx_decode.sv =====
module lnx_decode
   import lnx_pkg::*;
(
   input  logic [1:0]   operation,
   input  logic [2:0]   pin_index,
   input  logic         pin_value,
   input  logic         register_select,
   input  logic [7:0]   data_byte,
   input  logic [5:0]   column,
   input  logic [1:0]   row,
   output lnx_item_type item
);

   logic [7:0] ddram_addr;

   // Line base plus column, wrapped to 8 bits
   assign ddram_addr = ROW_BASE[row] + {2'b00, column};

   // Turn the operation into a pin update plan
   always_comb begin
      item.is_pin    = 1'b0;
      item.pin       = pin_index;
      item.level     = pin_value;
      item.rs        = register_select;
      item.data      = data_byte;
      item.last_step = STEP_LO_RELEASE;
      case (operation)
         OP_SET_PIN: begin
            item.is_pin    = 1'b1;
            item.last_step = STEP_RS;
         end
         OP_SEND_BYTE: begin
            item.last_step = STEP_LO_RELEASE;
         end
         OP_SEND_NIBBLE: begin
            item.last_step = STEP_HI_RELEASE;
         end
         OP_CURSOR: begin
            item.rs   = 1'b0;
            item.data = CMD_SET_DDRAM | ddram_addr;
         end
         default: begin
            item.last_step = STEP_LO_RELEASE;
         end
      endcase
   end

endmodule

// ===== rtl/lnx_stepper.sv =====
module lnx_stepper
   import lnx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  lnx_item_type  in_item,
   output logic          in_ready,
   input  logic          room,
   output logic          wr_valid,
   output lnx_write_type wr
);

   lnx_item_type   item_ff;
   logic           item_valid_ff;
   logic           item_valid_in;
   logic [3:0]     step_ff;
   logic [3:0]     step_in;
   logic [7:0]     shadow_ff;
   logic [7:0]     shadow_in;
   lnx_update_type update;
   logic           at_last;
   logic           in_fire;

   assign at_last  = (step_ff == item_ff.last_step);
   assign wr_valid = item_valid_ff && room;
   assign in_ready = !item_valid_ff || (room && at_last);
   assign in_fire  = in_valid && in_ready;

   // Pick the pin change for the current position
   always_comb begin
      if (item_ff.is_pin) begin
         update.pin   = item_ff.pin;
         update.level = item_ff.level;
      end else begin
         update = lnx_step(step_ff, item_ff.rs, item_ff.data);
      end
   end

   // Apply it to the shadow
   always_comb begin
      shadow_in = shadow_ff;
      if (wr_valid) begin
         shadow_in[update.pin] = update.level;
      end
   end

   assign wr.expander_byte = shadow_in;
   assign wr.last          = at_last;

   // Advance through the sequence, load the next item when idle or on the last write
   always_comb begin
      item_valid_in = item_valid_ff;
      step_in       = step_ff;
      if (in_fire) begin
         item_valid_in = 1'b1;
         step_in       = STEP_RS;
      end else if (wr_valid) begin
         if (at_last) begin
            item_valid_in = 1'b0;
            step_in       = STEP_RS;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         step_ff       <= STEP_RS;
         shadow_ff     <= 8'h00;
      end else begin
         item_valid_ff <= item_valid_in;
         step_ff       <= step_in;
         shadow_ff     <= shadow_in;
      end
   end

   // Hold the item payload
   always_ff @(posedge clock) begin
      if (in_fire) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== rtl/lnx_out_stage.sv =====
module lnx_out_stage
   import lnx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_valid,
   input  lnx_write_type wr,
   input  logic [7:0]    address,
   output logic          room,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [7:0]    out_address,
   output logic [7:0]    out_byte,
   output logic          out_last
);

   logic          valid_ff;
   logic          valid_in;
   lnx_write_type wr_ff;
   logic [7:0]    address_ff;

   assign room      = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   // Hold while stalled, drop once taken, load a new write
   always_comb begin
      valid_in = valid_ff;
      if (wr_valid) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         wr_ff      <= wr;
         address_ff <= address;
      end
   end

   assign out_address = address_ff;
   assign out_byte    = wr_ff.expander_byte;
   assign out_last    = wr_ff.last;

endmodule

// ===== rtl/lcd_nibble_expander_sequencer.sv =====
// Character display sequencer for a 4-bit display behind an 8-bit port expander.
// Each request item becomes a run of expander writes, one per response item:
// set pin gives 1 write, send byte and cursor position give 15, send high nibble
// gives 9. Every write carries the whole pin shadow (bit 0 RS, 1 RW, 2 EN,
// 3 backlight, 4..7 D4..D7) and the expander address from the csr register;
// last marks the final write of an item. The sequencer changes one shadow pin
// per cycle while the response register has room, and the next item is taken in
// the cycle its predecessor's last write issues. The response register lets a
// new item in while a finished write still waits.
// Reset clears the shadow to all pins low and the address to 78. Write the
// csr register only while no item is in flight.
module lcd_nibble_expander_sequencer
   import lnx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lnx_req_if.sink    req_ch,
   lnx_rsp_if.source  rsp_ch,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic [7:0]    addr_ff;
   logic [7:0]    addr_in;
   lnx_item_type  item;
   logic          room;
   logic          wr_valid;
   lnx_write_type wr;

   // Expander address register
   assign addr_in = csr_wr_en ? csr_wr_data : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= ADDR_RESET;
      end else begin
         addr_ff <= addr_in;
      end
   end

   lnx_decode u_decode (
      .operation       (req_ch.operation),
      .pin_index       (req_ch.pin_index),
      .pin_value       (req_ch.pin_value),
      .register_select (req_ch.register_select),
      .data_byte       (req_ch.data_byte),
      .column          (req_ch.column),
      .row             (req_ch.row),
      .item            (item)
   );

   lnx_stepper u_stepper (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_item  (item),
      .in_ready (req_ch.ready),
      .room     (room),
      .wr_valid (wr_valid),
      .wr       (wr)
   );

   lnx_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .wr_valid    (wr_valid),
      .wr          (wr),
      .address     (addr_ff),
      .room        (room),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_address (rsp_ch.bus_address),
      .out_byte    (rsp_ch.expander_byte),
      .out_last    (rsp_ch.last)
   );

endmodule

// ===== rtl/lnx_checker.sv =====
module lnx_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_bus_address,
   input logic [7:0] rsp_expander_byte,
   input logic       rsp_last
);

   // No response item right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_expander_byte)
         && $stable(rsp_bus_address) && $stable(rsp_last))
      else $error("stalled response item changed");

   // A taken write that is not the last is followed at once by the next one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside an item's write sequence");

   // Consecutive writes of one item change at most one pin
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         $countones(rsp_expander_byte ^ $past(rsp_expander_byte)) <= 1)
      else $error("more than one pin changed between writes");

endmodule

bind lcd_nibble_expander_sequencer lnx_checker u_lnx_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_bus_address   (rsp_ch.bus_address),
   .rsp_expander_byte (rsp_ch.expander_byte),
   .rsp_last          (rsp_ch.last)
);

// ===== bench/testbench.sv =====
module testbench;
   import lnx_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 40;

   // One request item as the host issues it
   typedef struct packed {
      logic [1:0] operation;
      logic [2:0] pin_index;
      logic       pin_value;
      logic       register_select;
      logic [7:0] data_byte;
      logic [5:0] column;
      logic [1:0] row;
   } lcd_cmd_type;

   // One expander write as it should leave the block
   typedef struct packed {
      logic [7:0] bus_address;
      logic [7:0] expander_byte;
      logic       last;
   } expander_write_type;

   logic clock;
   logic reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   lnx_req_if req_ch ();
   lnx_rsp_if rsp_ch ();

   lcd_nibble_expander_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Mirror of the pin shadow and the expander address
   logic [7:0]         shadow_pins;
   logic [7:0]         model_address;
   expander_write_type pending_writes [$];
   expander_write_type want_write;
   int                 mismatch_count;
   int                 cycle_count;
   bit                 gaps_on;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap lengths: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Update one shadow pin and queue the write it produces
   function automatic void model_pin(logic [2:0] pin, logic level);
      expander_write_type w;
      shadow_pins[pin] = level;
      w.bus_address    = model_address;
      w.expander_byte  = shadow_pins;
      w.last           = 1'b0;
      pending_writes.push_back(w);
   endfunction

   // Data lines D7 down to D4, then one enable strobe
   function automatic void model_nibble(logic [3:0] nib);
      for (int k = 0; k < 4; k++) begin
         model_pin(PIN_D7 - 3'(k), nib[3 - k]);
      end
      model_pin(PIN_EN, 1'b1);
      model_pin(PIN_EN, 1'b0);
   endfunction

   function automatic void model_transfer(logic rs, logic [7:0] data, bit full);
      model_pin(PIN_RS, rs);
      model_pin(PIN_RW, 1'b0);
      model_pin(PIN_EN, 1'b0);
      model_nibble(data[7:4]);
      if (full) model_nibble(data[3:0]);
   endfunction

   // Expected writes of one accepted item; flag the final one
   function automatic void predict_writes(lcd_cmd_type c);
      logic [7:0]         cmd;
      expander_write_type w;
      case (c.operation)
         OP_SET_PIN:     model_pin(c.pin_index, c.pin_value);
         OP_SEND_BYTE:   model_transfer(c.register_select, c.data_byte, 1'b1);
         OP_SEND_NIBBLE: model_transfer(c.register_select, c.data_byte, 1'b0);
         default: begin
            cmd = CMD_SET_DDRAM | 8'(ROW_BASE[c.row] + {2'b00, c.column});
            model_transfer(1'b0, cmd, 1'b1);
         end
      endcase
      w = pending_writes.pop_back();
      w.last = 1'b1;
      pending_writes.push_back(w);
   endfunction

   function automatic lcd_cmd_type random_cmd();
      lcd_cmd_type c;
      c.operation       = 2'($urandom_range(0, 3));
      c.pin_index       = 3'($urandom_range(0, 7));
      c.pin_value       = 1'($urandom_range(0, 1));
      c.register_select = 1'($urandom_range(0, 1));
      c.data_byte       = 8'($urandom_range(0, 255));
      c.column          = 6'($urandom_range(0, 63));
      c.row             = 2'($urandom_range(0, 3));
      return c;
   endfunction

   // Drive one item, hold it until taken, then predict its writes
   task automatic send_item(lcd_cmd_type c);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.operation       = c.operation;
      req_ch.pin_index       = c.pin_index;
      req_ch.pin_value       = c.pin_value;
      req_ch.register_select = c.register_select;
      req_ch.data_byte       = c.data_byte;
      req_ch.column          = c.column;
      req_ch.row             = c.row;
      req_ch.valid           = 1'b1;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
      end
      predict_writes(c);
   endtask

   // Drop valid and wait until every expected write has come out
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_expander_addr(logic [7:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      model_address = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Shorthands for directed items; unused fields carry random noise
   task automatic send_pin(logic [2:0] pin, logic level);
      lcd_cmd_type c;
      c           = random_cmd();
      c.operation = OP_SET_PIN;
      c.pin_index = pin;
      c.pin_value = level;
      send_item(c);
   endtask

   task automatic send_data(logic [1:0] op, logic rs, logic [7:0] data);
      lcd_cmd_type c;
      c                 = random_cmd();
      c.operation       = op;
      c.register_select = rs;
      c.data_byte       = data;
      send_item(c);
   endtask

   task automatic send_cursor(logic [1:0] row, logic [5:0] column);
      lcd_cmd_type c;
      c           = random_cmd();
      c.operation = OP_CURSOR;
      c.row       = row;
      c.column    = column;
      send_item(c);
   endtask

   // Address after reset must show on the first write
   task automatic test_reset_address();
      send_pin(3'd3, 1'b1);
      drain();
   endtask

   // Raise every pin in turn, then drop the outer two
   task automatic test_pin_updates();
      for (int p = 0; p < 8; p++) send_pin(3'(p), 1'b1);
      send_pin(PIN_D7, 1'b0);
      send_pin(PIN_RS, 1'b0);
      drain();
   endtask

   task automatic test_byte_transfers();
      load_expander_addr(8'h00);
      send_data(OP_SEND_BYTE, 1'b0, 8'h00);
      send_data(OP_SEND_BYTE, 1'b1, 8'hFF);
      send_data(OP_SEND_BYTE, 1'b1, 8'hA5);
      drain();
   endtask

   task automatic test_nibble_transfers();
      load_expander_addr(8'hFF);
      send_data(OP_SEND_NIBBLE, 1'b1, 8'hF0);
      send_data(OP_SEND_NIBBLE, 1'b0, 8'h3C);
      drain();
   endtask

   // Every line base, the first column and columns past the line end
   task automatic test_cursor_moves();
      send_cursor(2'd0, 6'd0);
      send_cursor(2'd1, 6'd63);
      send_cursor(2'd2, 6'd19);
      send_cursor(2'd3, 6'd63);
      drain();
   endtask

   task automatic test_random_traffic(logic [7:0] address, int count, bit with_gaps);
      load_expander_addr(address);
      gaps_on = with_gaps;
      for (int i = 0; i < count; i++) send_item(random_cmd());
      drain();
      gaps_on = 1'b1;
   endtask

   // Response side: random stalls, none while gaps are switched off
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if (gaps_on) stall_left = pick_gap();
         end
      end
   end

   // Compare each write with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected write addr %02h byte %02h last %0b", $time,
                     rsp_ch.bus_address, rsp_ch.expander_byte, rsp_ch.last);
            mismatch_count++;
         end else begin
            want_write = pending_writes.pop_front();
            if (rsp_ch.bus_address !== want_write.bus_address) begin
               $display("%0t: bus_address expected %02h actual %02h", $time,
                        want_write.bus_address, rsp_ch.bus_address);
               mismatch_count++;
            end
            if (rsp_ch.expander_byte !== want_write.expander_byte) begin
               $display("%0t: expander_byte expected %02h actual %02h", $time,
                        want_write.expander_byte, rsp_ch.expander_byte);
               mismatch_count++;
            end
            if (rsp_ch.last !== want_write.last) begin
               $display("%0t: last expected %0b actual %0b", $time,
                        want_write.last, rsp_ch.last);
               mismatch_count++;
            end
         end
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d writes outstanding", pending_writes.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_wr_data            = 8'h00;
      req_ch.valid           = 1'b0;
      req_ch.operation       = OP_SET_PIN;
      req_ch.pin_index       = 3'd0;
      req_ch.pin_value       = 1'b0;
      req_ch.register_select = 1'b0;
      req_ch.data_byte       = 8'h00;
      req_ch.column          = 6'd0;
      req_ch.row             = 2'd0;
      shadow_pins            = 8'h00;
      model_address          = ADDR_RESET;
      mismatch_count         = 0;
      cycle_count            = 0;
      gaps_on                = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_address();
      test_pin_updates();
      test_byte_transfers();
      test_nibble_transfers();
      test_cursor_moves();
      test_random_traffic(8'h00, 80, 1'b1);
      test_random_traffic(8'hFF, 60, 1'b0);
      test_random_traffic(8'($urandom_range(1, 254)), 90, 1'b1);
      test_random_traffic(ADDR_RESET, 70, 1'b1);

      // Let any stray write show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_writes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
